[rtl/core/bpa_pkg.sv]
// bpa_pkg: shared constants, codes, controller states and command/status structs
// for the buddy page allocator; no dependencies
package bpa_pkg;

	localparam int MAX_ORDER_TOP_DEF = 10;
	localparam int TOP_BLOCKS_DEF    = 4;
	localparam int PAGE_W            = 20;
	localparam int ORDER_W           = 4;
	localparam int STATUS_W          = 2;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_BAD_ORDER = 2'd1,
		STS_NO_MEM    = 2'd2,
		STS_NO_BUDDY  = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		PAIR_INV = 2'd0,
		PAIR_SET = 2'd1,
		PAIR_CLR = 2'd2
	} pair_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_POP,
		ST_POP_W,
		ST_SPLIT_A,
		ST_SPLIT_B,
		ST_TGT_W,
		ST_FREE_A,
		ST_FREE_B,
		ST_WALK,
		ST_WALK_W,
		ST_FOUND,
		ST_FOUND_W,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic     load;
		logic     clr_step;
		logic     o_load;
		logic     o_inc;
		logic     o_dec;
		logic     pop_one;
		logic     pop_rd;
		logic     pop_fin;
		logic     split_push;
		logic     pair_rd;
		logic     pair_wr;
		pair_op_t pair_op;
		logic     push_b;
		logic     walk_start;
		logic     walk_rd;
		logic     walk_fin;
		logic     found_rd;
		logic     found_fin;
		logic     st_set;
		status_t  st_code;
		logic     res_set;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic bad_req;
		logic o_top;
		logic o_tgt;
		logic head_nil;
		logic head_eq_tail;
		logic pair_bit;
		logic t_eq_buddy;
		logic t_eq_tail;
		logic cnt_max;
		logic clr_last;
		logic out_full;
		logic out_ready;
	} dp_sts_t;

endpackage

[rtl/core/bpa_if.sv]
// bpa_if: request and response channel interfaces of the buddy page allocator
// depends on bpa_pkg for field widths
interface bpa_req_if import bpa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [ORDER_W-1:0]   order;
	logic [PAGE_W-1:0]    page_number;

	modport source (output valid, output action, output order, output page_number,
		input ready);
	modport sink (input valid, input action, input order, input page_number,
		output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [PAGE_W-1:0]    page_number_out;

	modport source (output valid, output status, output page_number_out, input ready);
	modport sink (input valid, input status, input page_number_out, output ready);
endinterface

[rtl/core/bpa_ram.sv]
// bpa_ram: generic one-write one-read RAM with registered read data
// no dependencies
module bpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/bpa_dp.sv]
// bpa_dp: allocator datapath - request registers, free list heads and tails,
// link and pair-bit memories, response register; uses bpa_pkg and bpa_ram
module bpa_dp import bpa_pkg::*; #(
	parameter int MAX_ORDER_TOP = MAX_ORDER_TOP_DEF,
	parameter int TOP_BLOCKS    = TOP_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	input  logic                req_action,
	input  logic [ORDER_W-1:0]  req_order,
	input  logic [PAGE_W-1:0]   req_page,
	input  logic                cfg_wr_en,
	input  logic [PAGE_W-1:0]   cfg_wr_data,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic [STATUS_W-1:0] rsp_status,
	output logic [PAGE_W-1:0]   rsp_page
);

	localparam int TOTAL = TOP_BLOCKS << MAX_ORDER_TOP;
	localparam int BLK   = 1 << MAX_ORDER_TOP;
	localparam int PW    = $clog2(TOTAL);
	localparam int LW    = PW + 1;
	localparam int NL    = MAX_ORDER_TOP + 1;
	localparam int OW    = $clog2(NL);
	localparam logic [LW-1:0] NIL = LW'(TOTAL);

	// request and working registers
	logic                action_q;
	logic [ORDER_W-1:0]  order_q;
	logic [PAGE_W-1:0]   page_q;
	logic [PAGE_W-1:0]   base_q;
	logic [OW-1:0]       o_q;
	logic [PW-1:0]       b_q;
	logic [PW-1:0]       t_q;
	logic [LW-1:0]       cnt_q;
	logic [PW-1:0]       clr_q;
	status_t             status_q;
	logic [PAGE_W-1:0]   res_q;
	logic [LW-1:0]       head_q [NL];
	logic [LW-1:0]       tail_q [NL];
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [PAGE_W-1:0]   out_page_q;

	// memory ports
	logic          next_we, prev_we, pair_we;
	logic [PW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata, pair_waddr;
	logic          pair_wdata;
	logic          next_re, prev_re, pair_re;
	logic [PW-1:0] next_raddr, next_rdata, prev_rdata, pair_raddr;
	logic          pair_rdata;

	logic [OW-1:0]     lidx;
	logic [LW-1:0]     head_sel, tail_sel;
	logic              head_nil;
	logic [PAGE_W-1:0] diff;
	logic [31:0]       ord_w;
	logic              bad_alloc, bad_free;
	logic [PW-1:0]     pos_cur, buddy, half, push_pg;
	logic              push_en;
	logic              t_is_head, t_is_tail;
	logic              clr_aligned;
	logic [PW-1:0]     clr_next, clr_prev;

	// pair bit index: per order a region of TOTAL >> (o + 1) bits
	function automatic logic [PW-1:0] bit_pos(input logic [OW-1:0] o, input logic [PW-1:0] pg);
		logic [LW-1:0] off;
		logic [OW:0]   sh;
		off = NIL - (NIL >> o);
		sh  = (OW+1)'(o) + (OW+1)'(1);
		return PW'(off + LW'(pg >> sh));
	endfunction

	assign lidx     = cmd.split_push ? OW'(o_q - OW'(1)) : o_q;
	assign head_sel = head_q[lidx];
	assign tail_sel = tail_q[lidx];
	assign head_nil = (head_sel == NIL);

	assign diff      = page_q - base_q;
	assign ord_w     = 32'(order_q);
	assign bad_alloc = (ord_w >= 32'(MAX_ORDER_TOP));
	assign bad_free  = (ord_w > 32'(MAX_ORDER_TOP)) || (32'(diff) >= 32'(TOTAL))
		|| ((diff & ((PAGE_W'(1) << order_q) - PAGE_W'(1))) != '0);

	assign pos_cur = bit_pos(o_q, b_q);
	assign buddy   = b_q ^ (PW'(1) << o_q);
	assign half    = PW'(1) << OW'(o_q - OW'(1));
	assign push_en = cmd.split_push | cmd.push_b;
	assign push_pg = cmd.split_push ? PW'(b_q + half) : b_q;

	assign t_is_head = (LW'(t_q) == head_sel);
	assign t_is_tail = (LW'(t_q) == tail_sel);

	// reset image of the links: top blocks chained in ascending order
	assign clr_aligned = ((clr_q & PW'(BLK - 1)) == '0);
	assign clr_next = (clr_aligned && (LW'(clr_q) + LW'(BLK) < NIL)) ? PW'(clr_q + PW'(BLK)) : '0;
	assign clr_prev = (clr_aligned && (clr_q != '0)) ? PW'(clr_q - PW'(BLK)) : '0;

	always_comb begin
		next_we    = 1'b0;
		next_waddr = clr_q;
		next_wdata = clr_next;
		prev_we    = 1'b0;
		prev_waddr = clr_q;
		prev_wdata = clr_prev;
		if (cmd.clr_step) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (push_en && !head_nil) begin
			next_we    = 1'b1;
			next_waddr = tail_sel[PW-1:0];
			next_wdata = push_pg;
			prev_we    = 1'b1;
			prev_waddr = push_pg;
			prev_wdata = tail_sel[PW-1:0];
		end else if (cmd.found_fin && !t_is_head && !t_is_tail) begin
			next_we    = 1'b1;
			next_waddr = prev_rdata;
			next_wdata = next_rdata;
			prev_we    = 1'b1;
			prev_waddr = next_rdata;
			prev_wdata = prev_rdata;
		end
	end

	always_comb begin
		pair_we    = cmd.clr_step | cmd.pair_wr;
		pair_waddr = cmd.clr_step ? clr_q : pos_cur;
		pair_wdata = 1'b0;
		if (!cmd.clr_step) begin
			case (cmd.pair_op)
				PAIR_INV: pair_wdata = ~pair_rdata;
				PAIR_SET: pair_wdata = 1'b1;
				PAIR_CLR: pair_wdata = 1'b0;
				default:  pair_wdata = 1'b0;
			endcase
		end
	end

	assign next_re    = cmd.pop_rd | cmd.walk_rd | cmd.found_rd;
	assign next_raddr = cmd.pop_rd ? head_sel[PW-1:0] : t_q;
	assign prev_re    = cmd.found_rd;
	assign pair_re    = cmd.pair_rd | cmd.split_push;
	assign pair_raddr = pos_cur;

	bpa_ram #(.WIDTH(PW), .DEPTH(TOTAL)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.re(next_re), .raddr(next_raddr), .rdata(next_rdata)
	);

	bpa_ram #(.WIDTH(PW), .DEPTH(TOTAL)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.re(prev_re), .raddr(t_q), .rdata(prev_rdata)
	);

	bpa_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_pair_ram (
		.clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
		.re(pair_re), .raddr(pair_raddr), .rdata(pair_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NL; k++) begin
				head_q[k] <= (k == MAX_ORDER_TOP) ? LW'(0) : NIL;
				tail_q[k] <= (k == MAX_ORDER_TOP) ? LW'(TOTAL - BLK) : NIL;
			end
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (cmd.clr_step) begin
				clr_q <= PW'(clr_q + PW'(1));
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.pop_one) begin
				head_q[lidx] <= NIL;
				tail_q[lidx] <= NIL;
			end
			if (cmd.pop_fin) begin
				head_q[lidx] <= LW'(next_rdata);
			end
			if (push_en) begin
				if (head_nil) begin
					head_q[lidx] <= LW'(push_pg);
				end
				tail_q[lidx] <= LW'(push_pg);
			end
			if (cmd.found_fin) begin
				if (t_is_head && t_is_tail) begin
					head_q[lidx] <= NIL;
					tail_q[lidx] <= NIL;
				end else if (t_is_head) begin
					head_q[lidx] <= LW'(next_rdata);
				end else if (t_is_tail) begin
					tail_q[lidx] <= LW'(prev_rdata);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req_action;
			order_q  <= req_order;
			page_q   <= req_page;
			status_q <= STS_OK;
			res_q    <= '0;
		end
		if (cmd.o_load) begin
			o_q <= OW'(order_q);
			b_q <= PW'(diff);
		end
		if (cmd.o_inc) begin
			o_q <= OW'(o_q + OW'(1));
		end
		if (cmd.o_dec) begin
			o_q <= OW'(o_q - OW'(1));
		end
		if (cmd.pop_one || cmd.pop_rd) begin
			b_q <= head_sel[PW-1:0];
		end
		if (cmd.walk_start) begin
			t_q   <= head_sel[PW-1:0];
			cnt_q <= '0;
		end
		if (cmd.walk_rd) begin
			cnt_q <= LW'(cnt_q + LW'(1));
		end
		if (cmd.walk_fin) begin
			t_q <= next_rdata;
		end
		if (cmd.found_fin) begin
			b_q <= b_q & ~(PW'(1) << o_q);
			o_q <= OW'(o_q + OW'(1));
		end
		if (cmd.st_set) begin
			status_q <= cmd.st_code;
		end
		if (cmd.res_set) begin
			res_q <= PAGE_W'(base_q + PAGE_W'(b_q));
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_page_q   <= res_q;
		end
	end

	assign sts.is_free      = (action_q == ACT_FREE);
	assign sts.bad_req      = (action_q == ACT_FREE) ? bad_free : bad_alloc;
	assign sts.o_top        = (o_q == OW'(MAX_ORDER_TOP));
	assign sts.o_tgt        = (o_q == OW'(order_q));
	assign sts.head_nil     = head_nil;
	assign sts.head_eq_tail = (head_sel == tail_sel);
	assign sts.pair_bit     = pair_rdata;
	assign sts.t_eq_buddy   = (t_q == buddy);
	assign sts.t_eq_tail    = t_is_tail;
	assign sts.cnt_max      = (cnt_q == NIL);
	assign sts.clr_last     = (clr_q == PW'(TOTAL - 1));
	assign sts.out_full     = out_valid_q;
	assign sts.out_ready    = rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_page   = out_page_q;

endmodule

[rtl/core/bpa_ctrl.sv]
// bpa_ctrl: allocator controller state machine, sequences the datapath
// through search, split, merge and list walks; uses bpa_pkg
module bpa_ctrl import bpa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:    if (req_valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (sts.bad_req) state_d = ST_RESP;
				else if (sts.is_free) state_d = ST_FREE_A;
				else state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (!sts.head_nil) state_d = ST_POP;
				else if (sts.o_top) state_d = ST_RESP;
			end
			ST_POP:     state_d = sts.head_eq_tail ? ST_SPLIT_A : ST_POP_W;
			ST_POP_W:   state_d = ST_SPLIT_A;
			ST_SPLIT_A: state_d = sts.o_tgt ? ST_TGT_W : ST_SPLIT_B;
			ST_SPLIT_B: state_d = ST_SPLIT_A;
			ST_TGT_W:   state_d = ST_RESP;
			ST_FREE_A:  state_d = sts.o_top ? ST_RESP : ST_FREE_B;
			ST_FREE_B: begin
				if (!sts.pair_bit || sts.head_nil) state_d = ST_RESP;
				else state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.t_eq_buddy) state_d = ST_FOUND;
				else if (sts.cnt_max || sts.t_eq_tail) state_d = ST_RESP;
				else state_d = ST_WALK_W;
			end
			ST_WALK_W:  state_d = ST_WALK;
			ST_FOUND:   state_d = ST_FOUND_W;
			ST_FOUND_W: state_d = ST_FREE_A;
			ST_RESP:    if (!sts.out_full || sts.out_ready) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_CHECK: begin
				if (sts.bad_req) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = STS_BAD_ORDER;
				end else begin
					cmd.o_load = 1'b1;
				end
			end
			ST_SEARCH: begin
				if (sts.head_nil && sts.o_top) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = STS_NO_MEM;
				end else if (sts.head_nil) begin
					cmd.o_inc = 1'b1;
				end
			end
			ST_POP: begin
				cmd.pop_one = sts.head_eq_tail;
				cmd.pop_rd  = !sts.head_eq_tail;
			end
			ST_POP_W: cmd.pop_fin = 1'b1;
			ST_SPLIT_A: begin
				cmd.pair_rd    = sts.o_tgt;
				cmd.split_push = !sts.o_tgt;
			end
			ST_SPLIT_B: begin
				cmd.pair_wr = !sts.o_top;
				cmd.pair_op = PAIR_INV;
				cmd.o_dec   = 1'b1;
			end
			ST_TGT_W: begin
				cmd.pair_wr = 1'b1;
				cmd.pair_op = PAIR_INV;
				cmd.res_set = 1'b1;
			end
			ST_FREE_A: begin
				cmd.push_b  = sts.o_top;
				cmd.pair_rd = !sts.o_top;
			end
			ST_FREE_B: begin
				cmd.pair_wr = 1'b1;
				if (!sts.pair_bit) begin
					cmd.push_b  = 1'b1;
					cmd.pair_op = PAIR_SET;
				end else begin
					cmd.pair_op = PAIR_CLR;
					if (sts.head_nil) begin
						cmd.st_set  = 1'b1;
						cmd.st_code = STS_NO_BUDDY;
					end else begin
						cmd.walk_start = 1'b1;
					end
				end
			end
			ST_WALK: begin
				if (!sts.t_eq_buddy) begin
					if (sts.cnt_max || sts.t_eq_tail) begin
						cmd.st_set  = 1'b1;
						cmd.st_code = STS_NO_BUDDY;
					end else begin
						cmd.walk_rd = 1'b1;
					end
				end
			end
			ST_WALK_W:  cmd.walk_fin = 1'b1;
			ST_FOUND:   cmd.found_rd = 1'b1;
			ST_FOUND_W: cmd.found_fin = 1'b1;
			ST_RESP:    cmd.out_load = !sts.out_full || sts.out_ready;
			default:    cmd = '0;
		endcase
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_CHECK))
		else $error("accepted request did not enter check");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!sts.out_full || sts.out_ready))
		else $error("response register overwritten while held");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |-> !sts.cnt_max)
		else $error("list walk exceeded its bound");

endmodule

[rtl/core/buddy_page_allocator_core.sv]
// buddy_page_allocator_core: top level of the binary buddy page allocator
// depends on bpa_pkg, bpa_if, bpa_ram, bpa_dp, bpa_ctrl
//
// channel   dir  handshake      payload
// req       in   valid/ready    action, order, page_number
// rsp       out  valid/ready    status, page_number_out
// cfg       in   cfg_wr_en      cfg_wr_data (pool_base_page)
//
// one request at a time; a rejected request passes through idle, check and resp
// allocate: idle, check, search per order tried, pop, pop_w if the popped list holds
// more than one block, split_a and split_b per split level, split_a, tgt_w, resp
// free: idle, check, free_a, below top order free_b, and per merge level walk and
// walk_w per list entry walked past, walk, found, found_w, back to free_a; then resp
// a walk stops after TOP_BLOCKS << MAX_ORDER_TOP steps; after reset a clearing pass
// over every page rebuilds the link and pair memories before the first request is taken
// the response register lets the next request in while a response waits;
// resp stalls only while the previous response is still held
module buddy_page_allocator_core import bpa_pkg::*; #(
	parameter int MAX_ORDER_TOP = MAX_ORDER_TOP_DEF,
	parameter int TOP_BLOCKS    = TOP_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	bpa_req_if.sink           req,
	bpa_rsp_if.source         rsp,
	input  logic              cfg_wr_en,
	input  logic [PAGE_W-1:0] cfg_wr_data
);

	// command and status between controller and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller: sequences search, split, merge and buddy walk
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: free lists, link memories, pair bits, response register
	bpa_dp #(
		.MAX_ORDER_TOP (MAX_ORDER_TOP),
		.TOP_BLOCKS    (TOP_BLOCKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_action  (req.action),
		.req_order   (req.order),
		.req_page    (req.page_number),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_status  (rsp.status),
		.rsp_page    (rsp.page_number_out)
	);

endmodule

[tb/buddy_page_allocator_core_chk.sv]
// buddy_page_allocator_core_chk: watches the request, response and config ports,
// predicts each response with its own buddy allocator copy and compares
// depends on bpa_pkg and bpa_if
module buddy_page_allocator_core_chk import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	bpa_req_if                req,
	bpa_rsp_if                rsp,
	input  logic              cfg_wr_en,
	input  logic [PAGE_W-1:0] cfg_wr_data,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOP_ORD = MAX_ORDER_TOP_DEF;
	localparam int NPAGES  = TOP_BLOCKS_DEF << TOP_ORD;
	localparam int NONE    = NPAGES;

	typedef struct {
		status_t          sts;
		logic [PAGE_W-1:0] pg;
	} alloc_rsp_t;

	logic [PAGE_W-1:0] base;
	int                nxt [NPAGES];
	int                prv [NPAGES];
	int                head [TOP_ORD+1];
	int                tail [TOP_ORD+1];
	bit                pair [NPAGES];
	alloc_rsp_t        want_q [$];

	function automatic int pair_index(int o, int pg);
		return (NPAGES - (NPAGES >> o)) + (pg >> (o + 1));
	endfunction

	function automatic void append_block(int o, int pg);
		if (head[o] == NONE) head[o] = pg;
		else begin
			nxt[tail[o]] = pg;
			prv[pg] = tail[o];
		end
		tail[o] = pg;
	endfunction

	function automatic int take_head(int o);
		int h;
		h = head[o];
		if (h == tail[o]) begin
			head[o] = NONE;
			tail[o] = NONE;
		end else head[o] = nxt[h];
		return h;
	endfunction

	function automatic bit remove_block(int o, int pg);
		int t;
		bit hit;
		t = head[o];
		hit = 0;
		if (t == NONE) return 0;
		for (int s = 0; s < NPAGES; s++) begin
			if (t == pg) begin
				hit = 1;
				break;
			end
			if (t == tail[o]) return 0;
			t = nxt[t];
		end
		if (!hit) return 0;
		if (t == head[o] && t == tail[o]) begin
			head[o] = NONE;
			tail[o] = NONE;
		end else if (t == head[o]) head[o] = nxt[t];
		else if (t == tail[o]) tail[o] = prv[t];
		else begin
			nxt[prv[t]] = nxt[t];
			prv[nxt[t]] = prv[t];
		end
		return 1;
	endfunction

	function automatic void clear_pool();
		base = '0;
		for (int k = 0; k < NPAGES; k++) begin
			nxt[k] = 0;
			prv[k] = 0;
			pair[k] = 0;
		end
		for (int k = 0; k <= TOP_ORD; k++) begin
			head[k] = NONE;
			tail[k] = NONE;
		end
		for (int k = 0; k < TOP_BLOCKS_DEF; k++) append_block(TOP_ORD, k << TOP_ORD);
	endfunction

	function automatic alloc_rsp_t serve(action_t act, int ord, logic [PAGE_W-1:0] page);
		alloc_rsp_t r;
		int i, b, o;
		r.sts = STS_OK;
		r.pg = '0;
		if (act == ACT_ALLOC) begin
			if (ord >= TOP_ORD) r.sts = STS_BAD_ORDER;
			else begin
				i = ord;
				while (i <= TOP_ORD && head[i] == NONE) i++;
				if (i > TOP_ORD) r.sts = STS_NO_MEM;
				else begin
					b = take_head(i);
					while (i > ord) begin
						if (i != TOP_ORD) pair[pair_index(i, b)] ^= 1'b1;
						append_block(i - 1, b + (1 << (i - 1)));
						i--;
					end
					pair[pair_index(ord, b)] ^= 1'b1;
					r.pg = base + PAGE_W'(b);
				end
			end
		end else begin
			b = int'(PAGE_W'(page - base));
			if (ord > TOP_ORD || b >= NPAGES || (b & ((1 << ord) - 1)) != 0)
				r.sts = STS_BAD_ORDER;
			else begin
				o = ord;
				forever begin
					if (o == TOP_ORD) begin
						append_block(o, b);
						break;
					end
					if (!pair[pair_index(o, b)]) begin
						append_block(o, b);
						pair[pair_index(o, b)] = 1;
						break;
					end
					pair[pair_index(o, b)] = 0;
					if (!remove_block(o, b ^ (1 << o))) begin
						r.sts = STS_NO_BUDDY;
						break;
					end
					b &= ~(1 << o);
					o++;
				end
			end
		end
		return r;
	endfunction

	assign pending = want_q.size();

	initial begin
		errors = 0;
		clear_pool();
	end

	always @(posedge clk) begin
		alloc_rsp_t w;
		if (!arst_n) begin
			clear_pool();
			want_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response: status %0d page %h",
							rsp.status, rsp.page_number_out);
				end else begin
					w = want_q.pop_front();
					if (rsp.status !== w.sts || rsp.page_number_out !== w.pg) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected status %0d page %h, got status %0d page %h",
								w.sts, w.pg, rsp.status, rsp.page_number_out);
					end
				end
			end
			if (req.valid && req.ready)
				want_q.push_back(serve(action_t'(req.action), int'(req.order),
					req.page_number));
			if (cfg_wr_en) base = cfg_wr_data;
		end
	end

	final begin
	end
endmodule

[tb/buddy_page_allocator_core_tb.sv]
// buddy_page_allocator_core_tb: drives allocate and free requests with random gaps
// and back-pressure, rewrites pool_base_page between phases, reports the verdict
// depends on bpa_pkg, bpa_if, buddy_page_allocator_core and the checker module
module buddy_page_allocator_core_tb;
	import bpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOP_ORD = MAX_ORDER_TOP_DEF;
	localparam int NPAGES  = TOP_BLOCKS_DEF << TOP_ORD;

	// a block we own: pool-relative page and its order
	typedef struct {
		int rel;
		int ord;
	} held_blk_t;

	typedef struct {
		action_t act;
		int      ord;
	} sent_req_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [PAGE_W-1:0] cfg_wr_data;
	int                errors;
	int                pending;
	bit                no_idle;
	logic [PAGE_W-1:0] cur_base;
	held_blk_t         held_q [$];
	sent_req_t         sent_q [$];

	bpa_req_if req ();
	bpa_rsp_if rsp ();

	buddy_page_allocator_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req.sink),
		.rsp         (rsp.source),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	buddy_page_allocator_core_chk i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.errors      (errors),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// generous fixed limit: clearing pass plus long list walks on every request
	initial begin
		#50ms;
		$display("buddy_page_allocator_core_tb: errors");
		$finish;
	end

	// track what we own, so that frees are mostly well formed
	always @(posedge clk) begin
		sent_req_t s;
		if (arst_n && rsp.valid && rsp.ready && sent_q.size() > 0) begin
			s = sent_q.pop_front();
			if (s.act == ACT_ALLOC && rsp.status == STS_OK)
				held_q.push_back('{int'(PAGE_W'(rsp.page_number_out - cur_base)), s.ord});
		end
		if (arst_n && req.valid && req.ready)
			sent_q.push_back('{action_t'(req.action), int'(req.order)});
	end

	// response side: random stall before each response, none in busy phases
	initial begin
		int gap;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			gap = no_idle ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp.valid && rsp.ready)) @(posedge clk);
		end
	end

	// entered and left at a falling edge; valid stays high into a zero gap
	task automatic put_req(action_t act, int ord, logic [PAGE_W-1:0] pg);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.action      <= act;
		req.order       <= ORDER_W'(ord);
		req.page_number <= pg;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic free_held(int idx);
		held_blk_t h;
		h = held_q[idx];
		held_q.delete(idx);
		put_req(ACT_FREE, h.ord, cur_base + PAGE_W'(h.rel));
	endtask

	// hold off until every response is back, then let the block settle
	task automatic drain();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0 || sent_q.size() != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic set_base(logic [PAGE_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_base  = v;
	endtask

	// mostly well-formed alloc/free traffic, some noise with any field value
	task automatic random_phase(int n);
		int r, ord;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				put_req(action_t'($urandom_range(0, 1)), $urandom_range(0, 15),
					PAGE_W'($urandom));
			else if (r < 11)
				put_req(ACT_FREE, $urandom_range(0, TOP_ORD),
					cur_base + PAGE_W'($urandom_range(0, NPAGES - 1)));
			else if (held_q.size() > 0 && (r < 52 || held_q.size() > 60))
				free_held($urandom_range(0, held_q.size() - 1));
			else begin
				ord = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TOP_ORD - 1)
					: $urandom_range(0, 3);
				put_req(ACT_ALLOC, ord, PAGE_W'($urandom));
			end
		end
	endtask

	initial begin
		logic [PAGE_W-1:0] bases [5];
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		req.valid       = 1'b0;
		req.action      = ACT_ALLOC;
		req.order       = '0;
		req.page_number = '0;
		no_idle         = 0;
		cur_base        = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bad orders on both actions, out of pool, misaligned
		put_req(ACT_ALLOC, TOP_ORD, '0);
		put_req(ACT_ALLOC, 15, '1);
		put_req(ACT_FREE, TOP_ORD + 1, '0);
		put_req(ACT_FREE, 0, PAGE_W'(NPAGES));
		put_req(ACT_FREE, 0, '1);
		put_req(ACT_FREE, 1, PAGE_W'(1));
		// smallest allocations split a whole top block
		put_req(ACT_ALLOC, 0, '0);
		put_req(ACT_ALLOC, 0, '0);
		drain();
		// double free of the first page: buddy is not in its list
		put_req(ACT_FREE, 0, cur_base + PAGE_W'(held_q[0].rel));
		put_req(ACT_FREE, 0, cur_base + PAGE_W'(held_q[0].rel));
		held_q.delete(0);
		// largest allocations until the pool runs dry
		for (int k = 0; k < 9; k++) put_req(ACT_ALLOC, TOP_ORD - 1, '0);
		drain();
		while (held_q.size() > 0) free_held(held_q.size() - 1);
		// free at top order straight into the top list
		put_req(ACT_FREE, TOP_ORD, PAGE_W'(3 << TOP_ORD));

		// phases under different pool bases, extremes among them
		bases[0] = '0;
		bases[1] = '1;
		bases[2] = PAGE_W'($urandom);
		bases[3] = PAGE_W'(20'hFFC00);
		bases[4] = PAGE_W'($urandom);
		for (int p = 0; p < 5; p++) begin
			set_base(bases[p]);
			no_idle = (p % 2 == 1);
			random_phase(205);
			no_idle = 0;
		end

		drain();
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("buddy_page_allocator_core_tb: clean");
		else
			$display("buddy_page_allocator_core_tb: errors");
		$finish;
	end
endmodule
